### rtl/biquad_cascade_iir_filter_macros.svh
// Assertion macros shared by the biquad cascade RTL.
`ifndef BIQUAD_CASCADE_IIR_FILTER_MACROS_SVH
`define BIQUAD_CASCADE_IIR_FILTER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define BQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define BQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### rtl/bq_pkg.sv
// Package with constants, coefficient tables and arithmetic helpers for the biquad cascade.
`default_nettype none
package bq_pkg;
  localparam int NumSectionsDef = 17;
  localparam int SampleWidthDef = 24;
  localparam int RomSections = 17;
  localparam int StateWidth = 32;
  localparam int CfgIdxWidth = 1;
  localparam logic [CfgIdxWidth-1:0] RegCoefSet = 1'b0;
  localparam logic [CfgIdxWidth-1:0] RegGain = 1'b1;
  localparam logic signed [31:0] GainReset = 32'sd268435456;
  localparam logic signed [31:0] Q30One = 32'sd1073741824;

  typedef struct packed {
    logic signed [31:0] b0;
    logic signed [31:0] b2;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
  } coef_t;

  function automatic logic signed [31:0] rom_gain(input logic set, input logic [2:0] k);
    logic signed [31:0] r;
    r = 32'sd0;
    if (!set) begin
      case (k)
        3'd0, 3'd1: r = 32'sd81106648;
        3'd2, 3'd3: r = 32'sd79020144;
        3'd4, 3'd5: r = 32'sd77527672;
        default:    r = 32'sd76754416;
      endcase
    end else begin
      case (k)
        3'd0, 3'd1: r = 32'sd125207344;
        3'd2, 3'd3: r = 32'sd120391352;
        3'd4, 3'd5: r = 32'sd117058944;
        default:    r = 32'sd115367048;
      endcase
    end
    return r;
  endfunction

  function automatic logic signed [31:0] rom_a1(input logic set, input logic [2:0] k);
    logic signed [31:0] r;
    r = 32'sd0;
    case ({set, k})
      4'd0:  r = -32'sd2060349695;
      4'd1:  r = -32'sd2139609600;
      4'd2:  r = -32'sd1971207680;
      4'd3:  r = -32'sd2124292864;
      4'd4:  r = -32'sd2106593408;
      4'd5:  r = -32'sd1915857920;
      4'd6:  r = -32'sd2085114240;
      4'd7:  r = -32'sd1900037888;
      4'd8:  r = -32'sd1847756928;
      4'd9:  r = -32'sd2050132864;
      4'd10: r = -32'sd1774989568;
      4'd11: r = -32'sd1981295257;
      4'd12: r = -32'sd1752526848;
      4'd13: r = -32'sd1909026048;
      4'd14: r = -32'sd1836716160;
      default: r = -32'sd1777757952;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] rom_a2(input logic set, input logic [2:0] k);
    logic signed [31:0] r;
    r = 32'sd0;
    case ({set, k})
      4'd0:  r = 32'sd1018508032;
      4'd1:  r = 32'sd1066412736;
      4'd2:  r = 32'sd925112128;
      4'd3:  r = 32'sd1051147968;
      4'd4:  r = 32'sd1033580992;
      4'd5:  r = 32'sd863893504;
      4'd6:  r = 32'sd1012371264;
      4'd7:  r = 32'sd841882432;
      4'd8:  r = 32'sd1010613376;
      4'd9:  r = 32'sd1040046144;
      4'd10: r = 32'sd907387072;
      4'd11: r = 32'sd975101952;
      4'd12: r = 32'sd846573120;
      4'd13: r = 32'sd913741440;
      4'd14: r = 32'sd861666304;
      default: r = 32'sd833574848;
    endcase
    return r;
  endfunction

  // Coefficients of section j; sections past the band ROM are identity.
  function automatic coef_t section_coef(input logic set, input logic [5:0] j);
    coef_t c;
    c.b0 = Q30One;
    c.b2 = 32'sd0;
    c.a1 = 32'sd0;
    c.a2 = 32'sd0;
    if (j < 6'(RomSections - 1)) begin
      if (!j[0]) begin
        c.b0 = rom_gain(set, j[3:1]);
      end else begin
        c.b2 = -Q30One;
        c.a1 = rom_a1(set, j[3:1]);
        c.a2 = rom_a2(set, j[3:1]);
      end
    end
    return c;
  endfunction

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    logic signed [31:0] r;
    r = v[31:0];
    if (v > 67'sd2147483647) r = 32'sh7fffffff;
    else if (v < -67'sd2147483648) r = 32'sh80000000;
    return r;
  endfunction
endpackage
`default_nettype wire

### rtl/bq_if.sv
// Valid/ready channel interfaces for samples, results and register writes.
`default_nettype none
interface bq_stream_if #(parameter int Width = 24);
  logic valid;
  logic ready;
  logic [Width-1:0] sample_in;
  modport source (output valid, sample_in, input ready);
  modport sink (input valid, sample_in, output ready);
endinterface

interface bq_result_if #(parameter int Width = 24);
  logic valid;
  logic ready;
  logic [Width-1:0] sample_out;
  logic saturated;
  modport source (output valid, sample_out, saturated, input ready);
  modport sink (input valid, sample_out, saturated, output ready);
endinterface

interface bq_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/bq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module bq_ram #(
  parameter int Width = 32,
  parameter int Depth = 17
) (
  input  wire logic clk_i,
  input  wire logic we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/bq_mac.sv
// Section datapath: one shared 32x32 multiplier and a Q30 accumulator.
`default_nettype none
module bq_mac (
  input  wire logic clk_i,
  input  wire logic clr_i,
  input  wire logic en_i,
  input  wire logic signed [31:0] base_i,
  input  wire logic signed [31:0] op_a_i,
  input  wire logic signed [31:0] op_b_i,
  input  wire logic neg_i,
  output logic signed [31:0] result_o
);
  import bq_pkg::*;
  logic signed [66:0] acc_q, acc_d;
  logic signed [63:0] prod;

  assign prod = op_a_i * op_b_i;

  // Exact accumulation in Q.30 units; base is scaled by 2^30 when loaded on clear.
  always_comb begin
    acc_d = acc_q;
    if (clr_i) acc_d = {{5{base_i[31]}}, base_i, 30'd0};
    else if (en_i) acc_d = neg_i ? acc_q - 67'(prod) : acc_q + 67'(prod);
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Round half up by 2^30 then saturate.
  assign result_o = sat32((acc_q + 67'sd536870912) >>> 30);
endmodule
`default_nettype wire

### rtl/biquad_cascade_iir_filter.sv
// Top level of the biquad cascade IIR filter with delay state held in RAM.
//  channel   | dir | beat content
//  in_if     | in  | sample_in
//  out_if    | out | sample_out, saturated
//  cfg_if    | in  | index, data
// Each sample passes one gain step, then eight steps per section (RAM read wait,
// read, four products on the single shared multiplier, two result steps), then
// one output step, before the result is posted.
// A sample is taken only in the idle state, so the block does not take a new
// sample while it is still working through the last one.
// Reset clears the delay RAMs in a pass over all sections; no sample is
// taken during it. The result register holds until taken; a new sample is
// accepted only after it is gone.
`default_nettype none
`include "biquad_cascade_iir_filter_macros.svh"
module biquad_cascade_iir_filter #(
  parameter int NUM_SECTIONS = bq_pkg::NumSectionsDef,
  parameter int SAMPLE_WIDTH = bq_pkg::SampleWidthDef
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  bq_stream_if.sink in_if,
  bq_result_if.source out_if,
  bq_cfg_if.sink cfg_if
);
  import bq_pkg::*;
  localparam int AW = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
  localparam int RD = (NUM_SECTIONS > 1) ? NUM_SECTIONS : 2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_GAIN, S_GAIN_WAIT, S_READ, S_W1, S_W2, S_WDONE,
    S_Y0, S_Y2, S_YDONE, S_OUT
  } state_e;

  state_e state_q;
  logic coef_set_q;
  logic signed [31:0] gain_q;
  logic [AW-1:0] sec_q;
  logic signed [31:0] x_q, w_q, m1_q, m2_q;
  logic signed [SAMPLE_WIDTH-1:0] samp_q;
  logic out_valid_q;
  logic [SAMPLE_WIDTH-1:0] out_data_q;
  logic out_sat_q;

  logic signed [31:0] m1_rd, m2_rd, mac_res, op_a, op_b, base;
  logic mac_clr, mac_en, mac_neg, we;
  logic [31:0] wd1, wd2;
  coef_t coef;
  logic signed [63:0] gprod;
  logic signed [31:0] gx;

  assign coef = section_coef(coef_set_q, 6'(sec_q));

  // Delay RAMs: first holds w[n-1], second w[n-2].
  bq_ram #(.Width(StateWidth), .Depth(RD)) u_ram_first (
    .clk_i, .we_i(we), .waddr_i(sec_q), .wdata_i(wd1), .raddr_i(sec_q), .rdata_o(m1_rd));
  bq_ram #(.Width(StateWidth), .Depth(RD)) u_ram_second (
    .clk_i, .we_i(we), .waddr_i(sec_q), .wdata_i(wd2), .raddr_i(sec_q), .rdata_o(m2_rd));

  assign we = (state_q == S_CLEAR) || (state_q == S_YDONE);
  assign wd1 = (state_q == S_CLEAR) ? '0 : w_q;
  assign wd2 = (state_q == S_CLEAR) ? '0 : m1_q;

  // Input gain: Q1.x times Q4.28 reduced to Q8.24.
  assign gprod = samp_q * gain_q;
  assign gx = sat32(67'((gprod + (64'sd1 <<< (SAMPLE_WIDTH + 2))) >>> (SAMPLE_WIDTH + 3)));

  // Multiplier operand selection per step.
  always_comb begin
    op_a = coef.a1; op_b = m1_q; mac_neg = 1'b1; mac_en = 1'b0;
    mac_clr = 1'b0; base = x_q;
    case (state_q)
      S_READ:  begin mac_clr = 1'b1; base = x_q; end
      S_W1:    begin op_a = coef.a1; op_b = m1_q; mac_en = 1'b1; end
      S_W2:    begin op_a = coef.a2; op_b = m2_q; mac_en = 1'b1; end
      S_WDONE: begin mac_clr = 1'b1; base = 32'sd0; end
      S_Y0:    begin op_a = coef.b0; op_b = w_q; mac_neg = 1'b0; mac_en = 1'b1; end
      S_Y2:    begin op_a = coef.b2; op_b = m2_q; mac_neg = 1'b0; mac_en = 1'b1; end
      default: ;
    endcase
  end

  bq_mac u_mac (
    .clk_i, .clr_i(mac_clr), .en_i(mac_en), .base_i(base), .op_a_i(op_a),
    .op_b_i(op_b), .neg_i(mac_neg), .result_o(mac_res));

  // Output rounding from Q8.24 to the sample format with clip flag.
  logic signed [63:0] y_wide;
  logic y_hi, y_lo;
  always_comb begin
    if (SAMPLE_WIDTH >= 25) y_wide = 64'(x_q) <<< (SAMPLE_WIDTH - 25);
    else y_wide = (64'(x_q) + ((64'sd1 <<< (25 - SAMPLE_WIDTH)) >>> 1))
                  >>> (25 - SAMPLE_WIDTH);
    y_hi = y_wide > ((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    y_lo = y_wide < -(64'sd1 <<< (SAMPLE_WIDTH - 1));
  end

  assign in_if.ready = (state_q == S_IDLE) && !out_valid_q;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_q;
  assign out_if.sample_out = out_data_q;
  assign out_if.saturated = out_sat_q;

  // Sequencer: clear pass, gain, then per section read, w, y, write back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      sec_q <= '0;
      out_valid_q <= 1'b0;
      coef_set_q <= 1'b0;
      gain_q <= GainReset;
      samp_q <= '0;
      x_q <= '0;
      w_q <= '0;
      m1_q <= '0;
      m2_q <= '0;
      out_data_q <= '0;
      out_sat_q <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        if (cfg_if.index == RegCoefSet) coef_set_q <= cfg_if.data[0];
        else if (cfg_if.index == RegGain) gain_q <= cfg_if.data;
      end
      if (out_valid_q && out_if.ready) out_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          if (sec_q == AW'(NUM_SECTIONS - 1)) begin
            sec_q <= '0; state_q <= S_IDLE;
          end else sec_q <= sec_q + 1'b1;
        end
        S_IDLE: if (in_if.valid && !out_valid_q) begin
          samp_q <= in_if.sample_in; state_q <= S_GAIN;
        end
        S_GAIN: begin x_q <= gx; sec_q <= '0; state_q <= S_GAIN_WAIT; end
        S_GAIN_WAIT: state_q <= S_READ;
        S_READ: begin m1_q <= m1_rd; m2_q <= m2_rd; state_q <= S_W1; end
        S_W1: state_q <= S_W2;
        S_W2: state_q <= S_WDONE;
        S_WDONE: begin w_q <= mac_res; state_q <= S_Y0; end
        S_Y0: state_q <= S_Y2;
        S_Y2: state_q <= S_YDONE;
        S_YDONE: begin
          x_q <= mac_res;
          if (sec_q == AW'(NUM_SECTIONS - 1)) state_q <= S_OUT;
          else begin sec_q <= sec_q + 1'b1; state_q <= S_GAIN_WAIT; end
        end
        S_OUT: begin
          out_data_q <= y_hi ? SAMPLE_WIDTH'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1) :
                        y_lo ? SAMPLE_WIDTH'(-(64'sd1 <<< (SAMPLE_WIDTH - 1))) :
                        SAMPLE_WIDTH'(y_wide);
          out_sat_q <= y_hi || y_lo;
          out_valid_q <= 1'b1;
          sec_q <= '0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `BQ_ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, in_if.ready, state_q == S_IDLE, "ready outside idle")
  `BQ_ASSERT_NEXT(a_out_follows, clk_i, rst_ni, state_q == S_OUT, out_valid_q, "result not posted")
  `BQ_ASSERT_IMPL(a_write_ok, clk_i, rst_ni, we, state_q == S_CLEAR || state_q == S_YDONE, "bad write")
endmodule
`default_nettype wire

### verif/tb_biquad_pkg.sv
// Scoreboard class and bit-exact predictor of the biquad cascade output.
package tb_biquad_pkg;
  import bq_pkg::*;

  localparam int NumSec = bq_pkg::NumSectionsDef;
  localparam int SampW = bq_pkg::SampleWidthDef;

  typedef struct packed {
    logic [SampW-1:0] sample;
    logic clipped;
  } filt_out_t;

  class filter_scoreboard;
    logic coef_sel;
    logic signed [31:0] gain;
    logic signed [31:0] w_prev1[NumSec];
    logic signed [31:0] w_prev2[NumSec];
    filt_out_t pending_q[$];
    int errors;

    function new();
      coef_sel = 1'b0;
      gain = bq_pkg::GainReset;
      foreach (w_prev1[i]) begin
        w_prev1[i] = '0;
        w_prev2[i] = '0;
      end
      errors = 0;
    endfunction

    // Floor division by 2^k, then add one when the dropped part is at least half.
    static function automatic longint round_shift(longint v, int k);
      longint q;
      q = v >>> k;
      if (v[k-1]) q++;
      return q;
    endfunction

    static function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Sum of exact Q2.30 by Q8.24 products, rounded back to Q8.24.
    static function automatic longint q30_reduce(longint base, longint p0, longint p1,
                                                 longint p2);
      logic signed [71:0] acc;
      acc = (72'(signed'(base)) <<< 30) + 72'(signed'(p0)) + 72'(signed'(p1))
            + 72'(signed'(p2));
      acc = (acc >>> 30) + (acc[29] ? 72'sd1 : 72'sd0);
      if (acc > 72'sd2147483647) return 64'sd2147483647;
      if (acc < -72'sd2147483648) return -64'sd2147483648;
      return longint'(acc);
    endfunction

    function void write_reg(logic [0:0] idx, logic [31:0] data);
      if (idx == bq_pkg::RegCoefSet) coef_sel = data[0];
      else gain = data;
    endfunction

    // Run one sample through the cascade and store the expected beat.
    function void note_sample(logic [SampW-1:0] s_bits);
      longint x, w, m1, m2, y;
      coef_t c;
      filt_out_t r;
      x = clamp32(round_shift(longint'(signed'(s_bits)) * longint'(gain), SampW + 3));
      for (int j = 0; j < NumSec; j++) begin
        c = section_coef(coef_sel, 6'(j));
        m1 = w_prev1[j];
        m2 = w_prev2[j];
        w = q30_reduce(x, -(longint'(c.a1) * m1), -(longint'(c.a2) * m2), 0);
        x = q30_reduce(0, longint'(c.b0) * w, longint'(c.b2) * m2, 0);
        w_prev2[j] = m1;
        w_prev1[j] = w;
      end
      y = round_shift(x, 25 - SampW);
      r.clipped = 1'b0;
      if (y > (64'sd1 <<< (SampW - 1)) - 1) begin
        y = (64'sd1 <<< (SampW - 1)) - 1;
        r.clipped = 1'b1;
      end else if (y < -(64'sd1 <<< (SampW - 1))) begin
        y = -(64'sd1 <<< (SampW - 1));
        r.clipped = 1'b1;
      end
      r.sample = y[SampW-1:0];
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [SampW-1:0] s, logic sat);
      filt_out_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result sample_out=%h saturated=%b", $realtime, s, sat);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (s !== e.sample) begin
        $display("%0t: sample_out expected %h actual %h", $realtime, e.sample, s);
        errors++;
      end
      if (sat !== e.clipped) begin
        $display("%0t: saturated expected %b actual %b", $realtime, e.clipped, sat);
        errors++;
      end
    endfunction
  endclass
endpackage

### verif/tb_top.sv
// Top of the biquad cascade testbench: stimulus, register writes and checking.
module tb_top;
  import bq_pkg::*;
  import tb_biquad_pkg::*;

  localparam int CycleLimit = 900000;

  logic clk_i;
  logic rst_ni;
  bit calm;
  longint cycles;

  bq_stream_if #(.Width(SampW)) in_if ();
  bq_result_if #(.Width(SampW)) out_if ();
  bq_cfg_if cfg_if ();

  filter_scoreboard sb;

  biquad_cascade_iir_filter u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_if(in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Cycle counter with a hard limit on the run.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Result side: random stalls, check each accepted beat.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready)
        sb.check_result(out_if.sample_out, out_if.saturated);
      out_if.ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  // Each write starts after the previous one has dropped valid.
  task automatic write_reg(logic [0:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, data);
    cfg_if.valid <= 1'b0;
  endtask

  // Valid goes low between beats before the next beat is driven.
  task automatic send_sample(logic [SampW-1:0] s);
    @(posedge clk_i);
    if (!calm) begin
      while ($urandom_range(99) < 7) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.sample_in <= s;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_sample(s);
    in_if.valid <= 1'b0;
  endtask

  // Wait until every expected beat has come, then let the block settle.
  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // Mostly square-wave tones, else random samples, so the resonant sections see real signal.
  task automatic random_run(int n);
    int amp;
    int ph;
    int per;
    logic signed [31:0] v;
    amp = $urandom_range(8388607);
    per = $urandom_range(40, 4);
    ph = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 7) begin
        v = ((ph % per) < per / 2) ? amp : -amp;
        ph++;
      end else begin
        v = $urandom;
      end
      send_sample(v[SampW-1:0]);
    end
  endtask

  initial begin
    logic [31:0] gains[6];
    sb = new();
    calm = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.sample_in = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = bq_pkg::RegCoefSet;
    cfg_if.data = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes at reset settings, impulse and step.
    send_sample(24'h7fffff);
    send_sample(24'h800000);
    send_sample(24'h000000);
    send_sample(24'h000001);
    send_sample(24'hffffff);
    for (int i = 0; i < 5; i++) send_sample(24'h400000);
    drain();

    // Extreme gains provoke internal and output saturation, then zero gain.
    write_reg(bq_pkg::RegGain, 32'h7fffffff);
    write_reg(bq_pkg::RegCoefSet, 32'hfffffffe);
    send_sample(24'h7fffff);
    send_sample(24'h800000);
    send_sample(24'h7fffff);
    drain();
    write_reg(bq_pkg::RegGain, 32'h80000000);
    write_reg(bq_pkg::RegCoefSet, 32'h1);
    send_sample(24'h7fffff);
    send_sample(24'h800000);
    send_sample(24'h123456);
    drain();
    write_reg(bq_pkg::RegGain, 32'h0);
    send_sample(24'h7fffff);
    send_sample(24'h5a5a5a);
    drain();

    // Random phases across both coefficient sets and several gains.
    gains = '{32'h10000000, 32'h7fffffff, 32'h80000000, 32'hf0000000, 32'h40000000,
              32'h0};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(bq_pkg::RegCoefSet, {$urandom} & 32'hffff_ffff);
      write_reg(bq_pkg::RegGain, (ph < 6) ? gains[ph] : $urandom);
      calm = (ph == 3);
      random_run(95);
      drain();
    end
    calm = 1'b0;

    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl
rtl/bq_pkg.sv
rtl/bq_if.sv
rtl/bq_ram.sv
rtl/bq_mac.sv
rtl/biquad_cascade_iir_filter.sv
verif/tb_biquad_pkg.sv
verif/tb_top.sv
